// File: sv/dlcr_pkg.sv
// ----------------------------------------------------------------------------
// dlcr_pkg
// Shared types and constants for the line rasterizer with color interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

package dlcr_pkg;

    // fixed-point layout
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int DELTA_W    = COORD_BITS + 1;          // signed endpoint difference
    localparam int NORM_W     = COORD_BITS;              // max(|dx|,|dy|)
    localparam int DIV_W      = COORD_BITS + FRAC_BITS;  // dividend and quotient width
    localparam int ITER_W     = 5;                       // counts 0 .. DIV_W + 1
    localparam int POS_W      = 30;
    localparam int XSTEP_W    = 18;
    localparam int COL_W      = 25;
    localparam int WIN_W      = 13;
    localparam int INDEX_W    = 24;
    localparam int NUM_CHAN   = 5;

    // configuration register indexes
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // step channels, worked through one division at a time
    typedef enum logic [2:0] {
        CH_X     = 3'd0,
        CH_Y     = 3'd1,
        CH_RED   = 3'd2,
        CH_GREEN = 3'd3,
        CH_BLUE  = 3'd4
    } chan_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic  load;       // load word accepted
        logic  tick;       // tick word accepted
        logic  div_init;   // seed divider from chan
        logic  div_step;   // one restoring step
        logic  div_store;  // write signed quotient to step register of chan
        chan_t chan;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic norm_zero;   // incoming line has zero length
        logic pipe_free;   // pixel stage can take a tick this cycle
    } stat_t;

endpackage

`default_nettype wire

// File: sv/dlcr_ctrl.sv
// ----------------------------------------------------------------------------
// dlcr_ctrl
// Controller: input handshake and sequencing of the five step divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           opcode,
    input  wire dlcr_pkg::stat_t stat,
    output dlcr_pkg::cmd_t      cmd
);

    dlcr_pkg::state_t state_reg, state_next;
    dlcr_pkg::chan_t  chan_reg, chan_next;
    logic [dlcr_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlcr_pkg::ST_IDLE;
            chan_reg  <= dlcr_pkg::CH_X;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        iter_next  = iter_reg;
        in_stall   = 1'b1;
        accept     = 1'b0;
        cmd        = '0;
        cmd.chan   = chan_reg;
        case (state_reg)
            dlcr_pkg::ST_IDLE:
            begin
                in_stall = !stat.pipe_free;
                accept   = in_valid && stat.pipe_free;
                cmd.load = accept && (opcode == dlcr_pkg::OP_LOAD);
                cmd.tick = accept && (opcode == dlcr_pkg::OP_TICK);
                if (cmd.load && !stat.norm_zero)
                begin
                    state_next = dlcr_pkg::ST_DIV;
                    chan_next  = dlcr_pkg::CH_X;
                    iter_next  = '0;
                end
            end
            dlcr_pkg::ST_DIV:
            begin
                if (iter_reg == '0)
                begin
                    cmd.div_init = 1'b1;
                    iter_next    = iter_reg + 1'b1;
                end
                else if (iter_reg <= dlcr_pkg::ITER_W'(dlcr_pkg::DIV_W))
                begin
                    cmd.div_step = 1'b1;
                    iter_next    = iter_reg + 1'b1;
                end
                else
                begin
                    cmd.div_store = 1'b1;
                    iter_next     = '0;
                    if (chan_reg == dlcr_pkg::CH_BLUE)
                    begin
                        state_next = dlcr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        chan_next = dlcr_pkg::chan_t'(chan_reg + 3'd1);
                    end
                end
            end
            default:
            begin
                state_next = dlcr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/dlcr_datapath.sv
// ----------------------------------------------------------------------------
// dlcr_datapath
// Step divider, accumulators, pixel stage, output register and window regs.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dlcr_pkg::cmd_t      cmd,
    output dlcr_pkg::stat_t          stat,
    input  wire logic                wr_en,
    input  wire logic [0:0]          wr_index,
    input  wire logic [12:0]         wr_data,
    input  wire logic signed [11:0]  start_x,
    input  wire logic signed [11:0]  start_y,
    input  wire logic signed [11:0]  end_x,
    input  wire logic signed [11:0]  end_y,
    input  wire logic [7:0]          start_red,
    input  wire logic [7:0]          start_green,
    input  wire logic [7:0]          start_blue,
    input  wire logic [7:0]          end_red,
    input  wire logic [7:0]          end_green,
    input  wire logic [7:0]          end_blue,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     in_window,
    output logic [23:0]              pixel_index,
    output logic [23:0]              pixel_color,
    output logic                     last_of_line
);

    function automatic logic [dlcr_pkg::NORM_W-1:0] mag(
        input logic [dlcr_pkg::DELTA_W-1:0] v
    );
        logic [dlcr_pkg::DELTA_W-1:0] a;
        a = v[dlcr_pkg::DELTA_W-1] ? (~v + 1'b1) : v;
        return a[dlcr_pkg::NORM_W-1:0];
    endfunction

    // truncate toward zero, then clamp to 0..255
    function automatic logic [7:0] chan8(input logic [dlcr_pkg::COL_W-1:0] acc);
        logic [8:0] t;
        t = acc[24:16] + {8'b0, acc[24] && (acc[15:0] != '0)};
        return t[8] ? 8'd0 : t[7:0];
    endfunction

    // window registers
    logic [dlcr_pkg::WIN_W-1:0] width_reg, height_reg;

    // line setup
    logic [dlcr_pkg::DELTA_W-1:0] dx_w, dy_w, dr_w, dg_w, db_w;
    logic [dlcr_pkg::NORM_W-1:0]  ax_w, ay_w, norm_w;
    logic [dlcr_pkg::DELTA_W-1:0] delta_reg [0:dlcr_pkg::NUM_CHAN-1];
    logic [dlcr_pkg::NORM_W-1:0]  norm_reg;

    // divider
    logic [dlcr_pkg::NORM_W-1:0]  rem_reg, rem_next;
    logic [dlcr_pkg::DIV_W-1:0]   quo_reg, quo_next;
    logic                         neg_reg, neg_next;
    logic [dlcr_pkg::DELTA_W-1:0] sel_delta;
    logic [dlcr_pkg::NORM_W:0]    shifted, diff;
    logic                         fits;
    logic [dlcr_pkg::XSTEP_W-1:0] q_xy;
    logic [dlcr_pkg::COL_W-1:0]   q_col;

    // line state
    logic [dlcr_pkg::XSTEP_W-1:0] step_x_reg, step_y_reg;
    logic [dlcr_pkg::COL_W-1:0]   step_r_reg, step_g_reg, step_b_reg;
    logic [dlcr_pkg::POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [dlcr_pkg::COL_W-1:0]   red_reg, green_reg, blue_reg;
    logic [dlcr_pkg::NORM_W-1:0]  steps_left_reg;
    logic                         active_reg;

    // pixel stage and output register
    logic pix_v_reg, pix_last_reg, out_free;
    logic [13:0] xi, yi;
    logic pix_in_win;
    logic [24:0] prod;
    logic [23:0] index_w;
    logic out_valid_reg, in_window_reg, last_reg;
    logic [23:0] pixel_index_reg, pixel_color_reg;

    // ------------------------------------------------------------------ setup
    assign dx_w   = {end_x[11], end_x} - {start_x[11], start_x};
    assign dy_w   = {end_y[11], end_y} - {start_y[11], start_y};
    assign dr_w   = {5'b0, end_red}   - {5'b0, start_red};
    assign dg_w   = {5'b0, end_green} - {5'b0, start_green};
    assign db_w   = {5'b0, end_blue}  - {5'b0, start_blue};
    assign ax_w   = mag(dx_w);
    assign ay_w   = mag(dy_w);
    assign norm_w = (ax_w > ay_w) ? ax_w : ay_w;

    assign out_free = !out_valid_reg || !out_stall;
    assign stat     = '{norm_zero: (norm_w == '0), pipe_free: (!pix_v_reg || out_free)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dlcr_pkg::WIN_W'(640);
            height_reg <= dlcr_pkg::WIN_W'(480);
        end
        else if (wr_en)
        begin
            case (wr_index)
                dlcr_pkg::REG_WIDTH:  width_reg  <= wr_data;
                dlcr_pkg::REG_HEIGHT: height_reg <= wr_data;
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            delta_reg[dlcr_pkg::CH_X]     <= dx_w;
            delta_reg[dlcr_pkg::CH_Y]     <= dy_w;
            delta_reg[dlcr_pkg::CH_RED]   <= dr_w;
            delta_reg[dlcr_pkg::CH_GREEN] <= dg_w;
            delta_reg[dlcr_pkg::CH_BLUE]  <= db_w;
            norm_reg <= norm_w;
        end
    end

    // ---------------------------------------------------------------- divider
    // restoring divide of |delta|<<16 + norm/2 by norm, one quotient bit a cycle
    assign sel_delta = delta_reg[cmd.chan];
    assign shifted   = {rem_reg, quo_reg[dlcr_pkg::DIV_W-1]};
    assign diff      = shifted - {1'b0, norm_reg};
    assign fits      = shifted >= {1'b0, norm_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        if (cmd.div_init)
        begin
            rem_next = '0;
            quo_next = {mag(sel_delta),
                        {(dlcr_pkg::FRAC_BITS - dlcr_pkg::NORM_W + 1){1'b0}},
                        norm_reg[dlcr_pkg::NORM_W-1:1]};
            neg_next = sel_delta[dlcr_pkg::DELTA_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_next = fits ? diff[dlcr_pkg::NORM_W-1:0] : shifted[dlcr_pkg::NORM_W-1:0];
            quo_next = {quo_reg[dlcr_pkg::DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign q_xy  = neg_reg ? (~quo_reg[dlcr_pkg::XSTEP_W-1:0] + 1'b1)
                           : quo_reg[dlcr_pkg::XSTEP_W-1:0];
    assign q_col = neg_reg ? (~quo_reg[dlcr_pkg::COL_W-1:0] + 1'b1)
                           : quo_reg[dlcr_pkg::COL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.chan)
                dlcr_pkg::CH_X:     step_x_reg <= q_xy;
                dlcr_pkg::CH_Y:     step_y_reg <= q_xy;
                dlcr_pkg::CH_RED:   step_r_reg <= q_col;
                dlcr_pkg::CH_GREEN: step_g_reg <= q_col;
                dlcr_pkg::CH_BLUE:  step_b_reg <= q_col;
                default:            step_b_reg <= step_b_reg;
            endcase
        end
    end

    // ----------------------------------------------------------- accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_x_reg <= {{2{start_x[11]}}, start_x, 16'b0};
            pos_y_reg <= {{2{start_y[11]}}, start_y, 16'b0};
            red_reg   <= {1'b0, start_red, 16'b0};
            green_reg <= {1'b0, start_green, 16'b0};
            blue_reg  <= {1'b0, start_blue, 16'b0};
        end
        else if (cmd.tick && active_reg)
        begin
            pos_x_reg <= pos_x_reg + {{12{step_x_reg[17]}}, step_x_reg};
            pos_y_reg <= pos_y_reg + {{12{step_y_reg[17]}}, step_y_reg};
            red_reg   <= red_reg + step_r_reg;
            green_reg <= green_reg + step_g_reg;
            blue_reg  <= blue_reg + step_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            pix_v_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                steps_left_reg <= norm_w;
                active_reg     <= (norm_w != '0);
            end
            else if (cmd.tick && active_reg)
            begin
                steps_left_reg <= steps_left_reg - 1'b1;
                if (steps_left_reg == dlcr_pkg::NORM_W'(1))
                begin
                    active_reg <= 1'b0;
                end
            end

            if (cmd.tick && active_reg)
            begin
                pix_v_reg <= 1'b1;
            end
            else if (out_free)
            begin
                pix_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick && active_reg)
        begin
            pix_last_reg <= (steps_left_reg == dlcr_pkg::NORM_W'(1));
        end
    end

    // ------------------------------------------------------------ pixel stage
    assign xi = pos_x_reg[29:16] + {13'b0, pos_x_reg[29] && (pos_x_reg[15:0] != '0)};
    assign yi = pos_y_reg[29:16] + {13'b0, pos_y_reg[29] && (pos_y_reg[15:0] != '0)};
    assign pix_in_win = !xi[13] && !yi[13]
                        && (xi[12:0] < width_reg) && (yi[12:0] < height_reg);
    assign prod    = {13'b0, yi[11:0]} * {12'b0, width_reg};
    assign index_w = prod[23:0] + {12'b0, xi[11:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pix_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pix_v_reg)
        begin
            in_window_reg   <= pix_in_win;
            pixel_index_reg <= pix_in_win ? index_w : '0;
            pixel_color_reg <= {chan8(red_reg), chan8(green_reg), chan8(blue_reg)};
            last_reg        <= pix_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign in_window    = in_window_reg;
    assign pixel_index  = pixel_index_reg;
    assign pixel_color  = pixel_color_reg;
    assign last_of_line = last_reg;

endmodule

`default_nettype wire

// File: sv/dda_line_color_rasterizer_core.sv
// ----------------------------------------------------------------------------
// dda_line_color_rasterizer_core
// DDA line stepper with linear RGB interpolation and window clipping.
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall) takes one word per handshake:
//   opcode 0 loads a line (endpoints and colors), opcode 1 is a step tick
// a load produces no output; it sets up five fixed-point steps with a shared
//   one-bit-per-cycle restoring divider (seed, one step per quotient bit, store),
//   so in_stall is high after a load of nonzero length until all five are stored
// a tick while a line is active gives one pixel word on the output channel
//   (out_valid / out_stall) through the pixel stage and the output register; ticks
//   are taken back to back, one per cycle, as long as the output side keeps up
// a tick while idle and a zero-length load give no output
// when the receiver stalls, the output register holds its word and one more
//   pixel waits in the pixel stage; then in_stall rises until space frees
// window size is written through wr_en / wr_index / wr_data while idle
// reset (rst_n, async, active low) leaves the block idle, window 640 x 480
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_color_rasterizer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               wr_en,
    input  wire logic [0:0]         wr_index,
    input  wire logic [12:0]        wr_data,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic signed [11:0] start_x,
    input  wire logic signed [11:0] start_y,
    input  wire logic signed [11:0] end_x,
    input  wire logic signed [11:0] end_y,
    input  wire logic [7:0]         start_red,
    input  wire logic [7:0]         start_green,
    input  wire logic [7:0]         start_blue,
    input  wire logic [7:0]         end_red,
    input  wire logic [7:0]         end_green,
    input  wire logic [7:0]         end_blue,
    // output words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    in_window,
    output logic [23:0]             pixel_index,
    output logic [23:0]             pixel_color,
    output logic                    last_of_line
);

    // command and status between sequencer and datapath
    dlcr_pkg::cmd_t  cmd;
    dlcr_pkg::stat_t stat;

    // handshake and divide sequencing
    dlcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // divider, accumulators, clipping, index and output register
    dlcr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .start_red    (start_red),
        .start_green  (start_green),
        .start_blue   (start_blue),
        .end_red      (end_red),
        .end_green    (end_green),
        .end_blue     (end_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .in_window    (in_window),
        .pixel_index  (pixel_index),
        .pixel_color  (pixel_color),
        .last_of_line (last_of_line)
    );

endmodule

`default_nettype wire

// File: tb/dda_line_color_rasterizer_core_tb.sv
// ----------------------------------------------------------------------------
// dda_line_color_rasterizer_core_tb
// Self-checking bench for the line stepper: drives load and tick words under
// several window sizes and idle patterns, predicts every pixel word in fixed
// point and compares each field of the pixels as they leave the block.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_color_rasterizer_core_tb;

    // one word on the input channel
    typedef struct packed {
        logic                  op;
        logic signed [11:0]    sx;
        logic signed [11:0]    sy;
        logic signed [11:0]    ex;
        logic signed [11:0]    ey;
        logic [7:0]            r0;
        logic [7:0]            g0;
        logic [7:0]            b0;
        logic [7:0]            r1;
        logic [7:0]            g1;
        logic [7:0]            b1;
    } raster_word_t;

    // one pixel word on the output channel
    typedef struct packed {
        logic                           in_win;
        logic [dlcr_pkg::INDEX_W-1:0]   index;
        logic [23:0]                    color;
        logic                           last;
    } pixel_t;

    // ------------------------------------------------------------------------
    // pixel predictor and store of pixels still owed by the block
    // ------------------------------------------------------------------------
    class line_pixel_book;
        logic [dlcr_pkg::WIN_W-1:0]          win_w = 13'd640;
        logic [dlcr_pkg::WIN_W-1:0]          win_h = 13'd480;
        logic signed [dlcr_pkg::POS_W-1:0]   px;
        logic signed [dlcr_pkg::POS_W-1:0]   py;
        logic signed [dlcr_pkg::XSTEP_W-1:0] dx_step;
        logic signed [dlcr_pkg::XSTEP_W-1:0] dy_step;
        logic signed [dlcr_pkg::COL_W-1:0]   col_acc [3];
        logic signed [dlcr_pkg::COL_W-1:0]   col_step [3];
        int unsigned                         steps_to_go;
        bit                                  drawing;
        pixel_t                              pixels_due [$];
        int                                  errors;
        int                                  useful;
        int                                  loads;
        int                                  checked;

        // delta * 2^FRAC_BITS / span, nearest, ties away from zero
        function longint round_step(longint delta, longint span);
            longint q;
            q = (((delta < 0 ? -delta : delta) << dlcr_pkg::FRAC_BITS) + span / 2) / span;
            return delta < 0 ? -q : q;
        endfunction

        // integer part, toward zero
        function longint whole_part(longint acc);
            return acc < 0 ? -((-acc) >>> dlcr_pkg::FRAC_BITS) : acc >>> dlcr_pkg::FRAC_BITS;
        endfunction

        function logic [7:0] clamp_chan(longint acc);
            longint c;
            c = whole_part(acc);
            if (c < 0)
                return 8'd0;
            if (c > 255)
                return 8'd255;
            return 8'(c);
        endfunction

        function void note_word(raster_word_t w);
            longint sx, sy, ddx, ddy, ax, ay, span, xi, yi;
            longint c0 [3];
            longint c1 [3];
            pixel_t e;
            if (w.op == dlcr_pkg::OP_LOAD)
            begin
                useful++;
                sx  = longint'($signed(w.sx));
                sy  = longint'($signed(w.sy));
                ddx = longint'($signed(w.ex)) - sx;
                ddy = longint'($signed(w.ey)) - sy;
                ax  = ddx < 0 ? -ddx : ddx;
                ay  = ddy < 0 ? -ddy : ddy;
                span = ax > ay ? ax : ay;
                if (span == 0)
                begin
                    drawing = 1'b0;
                    steps_to_go = 0;
                    return;
                end
                loads++;
                c0 = '{longint'(w.r0), longint'(w.g0), longint'(w.b0)};
                c1 = '{longint'(w.r1), longint'(w.g1), longint'(w.b1)};
                px = dlcr_pkg::POS_W'(sx << dlcr_pkg::FRAC_BITS);
                py = dlcr_pkg::POS_W'(sy << dlcr_pkg::FRAC_BITS);
                dx_step = dlcr_pkg::XSTEP_W'(round_step(ddx, span));
                dy_step = dlcr_pkg::XSTEP_W'(round_step(ddy, span));
                for (int i = 0; i < 3; i++)
                begin
                    col_acc[i]  = dlcr_pkg::COL_W'(c0[i] << dlcr_pkg::FRAC_BITS);
                    col_step[i] = dlcr_pkg::COL_W'(round_step(c1[i] - c0[i], span));
                end
                steps_to_go = int'(span);
                drawing = 1'b1;
                return;
            end
            if (!drawing)
                return;
            useful++;
            px = px + dx_step;
            py = py + dy_step;
            for (int i = 0; i < 3; i++)
                col_acc[i] = col_acc[i] + col_step[i];
            steps_to_go--;
            xi = whole_part(longint'(px));
            yi = whole_part(longint'(py));
            e.in_win = xi >= 0 && yi >= 0 && xi < longint'(win_w) && yi < longint'(win_h);
            e.index  = e.in_win ? dlcr_pkg::INDEX_W'(yi * longint'(win_w) + xi) : '0;
            e.color  = {clamp_chan(longint'(col_acc[0])), clamp_chan(longint'(col_acc[1])),
                        clamp_chan(longint'(col_acc[2]))};
            e.last   = steps_to_go == 0;
            if (steps_to_go == 0)
                drawing = 1'b0;
            pixels_due.push_back(e);
        endfunction

        function void compare_field(string name, longint unsigned expv, longint unsigned gotv);
            if (expv != gotv)
            begin
                $error("%s: expected %0d, got %0d", name, expv, gotv);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t e;
            if (pixels_due.size() == 0)
            begin
                $error("pixel word with none expected: index %0d color %06h",
                       got.index, got.color);
                errors++;
                return;
            end
            e = pixels_due.pop_front();
            checked++;
            compare_field("in_window", e.in_win, got.in_win);
            compare_field("pixel_index", e.index, got.index);
            compare_field("pixel_color", e.color, got.color);
            compare_field("last_of_line", e.last, got.last);
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               wr_en;
    logic [0:0]         wr_index;
    logic [12:0]        wr_data;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic [7:0]         start_red;
    logic [7:0]         start_green;
    logic [7:0]         start_blue;
    logic [7:0]         end_red;
    logic [7:0]         end_green;
    logic [7:0]         end_blue;
    logic               out_valid;
    logic               out_stall;
    logic               in_window;
    logic [23:0]        pixel_index;
    logic [23:0]        pixel_color;
    logic               last_of_line;

    dda_line_color_rasterizer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .start_red    (start_red),
        .start_green  (start_green),
        .start_blue   (start_blue),
        .end_red      (end_red),
        .end_green    (end_green),
        .end_blue     (end_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .in_window    (in_window),
        .pixel_index  (pixel_index),
        .pixel_color  (pixel_color),
        .last_of_line (last_of_line)
    );

    line_pixel_book book = new;

    // idle and stall odds in percent, set per phase by the stimulus
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // long receiver hold-off, counted down by the receiver itself
    int hold_cycles   = 0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // receiver: random stalls at the falling edge, long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // pixel words are taken and checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_pixel('{in_window, pixel_index, pixel_color, last_of_line});
    end

    // ------------------------------------------------------------------------
    // sender tasks: everything changes at the falling edge
    // ------------------------------------------------------------------------

    // offer one word after a random idle gap and hold it until taken
    task automatic send_word(input raster_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= w.op;
        start_x     <= w.sx;
        start_y     <= w.sy;
        end_x       <= w.ex;
        end_y       <= w.ey;
        start_red   <= w.r0;
        start_green <= w.g0;
        start_blue  <= w.b0;
        end_red     <= w.r1;
        end_green   <= w.g1;
        end_blue    <= w.b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_word(w);
        @(negedge clk);
    endtask

    // tick word; the unused fields carry noise
    task automatic send_tick();
        logic [127:0] noise;
        raster_word_t w;
        noise = {$urandom, $urandom, $urandom, $urandom};
        w = noise[$bits(raster_word_t)-1:0];
        w.op = dlcr_pkg::OP_TICK;
        send_word(w);
    endtask

    // load word, colors packed as red, green, blue
    task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                             input logic [23:0] c0, input logic [23:0] c1);
        raster_word_t w;
        w.op = dlcr_pkg::OP_LOAD;
        w.sx = 12'(sx);
        w.sy = 12'(sy);
        w.ex = 12'(ex);
        w.ey = 12'(ey);
        {w.r0, w.g0, w.b0} = c0;
        {w.r1, w.g1, w.b1} = c1;
        send_word(w);
    endtask

    // drop valid and wait for every owed pixel
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    // coordinate: half over the whole range, half near the window
    function automatic int rand_coord(int span);
        int hi;
        if ($urandom_range(1) == 1)
            return int'($urandom_range(4095)) - 2048;
        hi = span + 16;
        if (hi > 2055)
            hi = 2055;
        return int'($urandom_range(hi)) - 8;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // color with a fair share of black, white and saturated channels
    function automatic logic [23:0] rand_color();
        logic [23:0] c;
        c = 24'($urandom);
        if ($urandom_range(3) == 0)
            c = c & {{8{c[0]}}, {8{c[1]}}, {8{c[2]}}} | {{8{c[3]}}, {8{c[4]}}, {8{c[5]}}};
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int ww;
        int wh;
        int target;
        int pick;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int norm;
        int ticks;
        int fails;

        // every input known from time zero, reset held low at the start
        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_index    = dlcr_pkg::REG_WIDTH;
        wr_data     = '0;
        in_valid    = 1'b0;
        opcode      = dlcr_pkg::OP_LOAD;
        start_x     = '0;
        start_y     = '0;
        end_x       = '0;
        end_y       = '0;
        start_red   = '0;
        start_green = '0;
        start_blue  = '0;
        end_red     = '0;
        end_green   = '0;
        end_blue    = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, reset window 640 x 480
        // tick with no line loaded
        send_tick();
        // zero-length line leaves the block idle
        send_load(5, 5, 5, 5, 24'hFFFFFF, 24'h000000);
        send_tick();
        // norm 7 with full color swings: rounded steps drift the green
        // channel just below zero on the last pixel
        send_load(0, 0, 7, 3, 24'h00FF00, 24'hFF0080);
        // one more tick after the line ends
        repeat (8) send_tick();
        // coordinate extremes, cut short by the next load
        send_load(-2048, -2048, 2047, 2047, 24'hFFFFFF, 24'h000000);
        repeat (3) send_tick();
        // runs across the bottom-right corner of the window
        send_load(637, 476, 640, 479, 24'hFF00FF, 24'h00FF00);
        repeat (3) send_tick();
        // negative direction, truncation toward zero around the origin
        send_load(1, 1, -2, -1, 24'h102030, 24'hF0E0D0);
        repeat (3) send_tick();

        for (phase = 0; phase < 6; phase++)
        begin
            // window writes only with the block idle; a load may still be
            // working through its divisions after the last pixel
            wait_drained();
            repeat (200) @(negedge clk);
            case (phase)
                0:
                begin
                    ww = 1;
                    wh = 4096;
                end
                1:
                begin
                    ww = 4096;
                    wh = 1;
                end
                2:
                begin
                    ww = 4096;
                    wh = 4096;
                end
                3:
                begin
                    ww = 0;
                    wh = 0;
                end
                4:
                begin
                    ww = int'($urandom_range(4096, 1));
                    wh = int'($urandom_range(4096, 1));
                end
                default:
                begin
                    ww = int'($urandom_range(64, 1));
                    wh = int'($urandom_range(64, 1));
                end
            endcase
            wr_en    <= 1'b1;
            wr_index <= dlcr_pkg::REG_WIDTH;
            wr_data  <= 13'(ww);
            @(negedge clk);
            wr_index <= dlcr_pkg::REG_HEIGHT;
            wr_data  <= 13'(wh);
            @(negedge clk);
            wr_en    <= 1'b0;
            book.win_w = 13'(ww);
            book.win_h = 13'(wh);

            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct = 31;
                    stall_pct = 31;
                end
            endcase

            if (phase == 4)
            begin
                // receiver holds off while ticks keep coming: the pixel
                // stage fills and in_stall must hold the sender back
                send_load(0, 0, 40, 17, 24'h000000, 24'hFFFFFF);
                hold_cycles = 400;
                repeat (40) send_tick();
                // sender pauses until every pixel is out
                wait_drained();
            end

            target = book.useful + 130;
            while (book.useful < target)
            begin
                pick = int'($urandom_range(99));
                if (pick < 6)
                begin
                    // stray tick, often while idle
                    send_tick();
                end
                else
                begin
                    sx = rand_coord(ww);
                    sy = rand_coord(wh);
                    if (pick < 11)
                    begin
                        ex = sx;
                        ey = sy;
                    end
                    else if (pick < 16)
                    begin
                        ex = int'($urandom_range(4095)) - 2048;
                        ey = int'($urandom_range(4095)) - 2048;
                    end
                    else
                    begin
                        span = (pick < 85) ? 24 : 200;
                        ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
                        ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
                    end
                    norm = (ex > sx) ? ex - sx : sx - ex;
                    if (((ey > sy) ? ey - sy : sy - ey) > norm)
                        norm = (ey > sy) ? ey - sy : sy - ey;
                    send_load(sx, sy, ex, ey, rand_color(), rand_color());
                    ticks = norm;
                    if (norm > 200)
                        ticks = int'($urandom_range(30, 1));
                    else if ($urandom_range(9) == 0)
                        ticks = int'($urandom_range(norm));
                    else if ($urandom_range(4) == 0)
                        ticks = norm + 1;
                    repeat (ticks) send_tick();
                end
            end
        end

        // all words sent: drain, then let any running load finish
        wait_drained();
        repeat (200) @(negedge clk);

        fails = book.errors + book.pending();
        $display("covered %0d line loads and %0d stepped pixels over 7 window settings",
                 book.loads, book.checked);
        $display("idle patterns: none, sender, receiver, both; one long receiver hold-off");
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard limit well above the slowest correct run
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
